/* rtl/utf8ld_pkg.sv */
// ----------------------------------------------------------------------------
// utf8ld_pkg
// Shared types and constants for the lenient six-byte UTF-8 decoder.
// ----------------------------------------------------------------------------
package utf8ld_pkg;

    localparam int CP_W     = 31;
    localparam int BYTE_W   = 8;
    localparam int REM_W    = 3;
    localparam int QDEPTH   = 2;
    localparam int QCNT_W   = 2;
    localparam int TDATA_W  = 32;

    localparam logic [7:0] LEAD_LO   = 8'hC0;
    localparam logic [7:0] LEAD_HI   = 8'hFE;  // exclusive
    localparam logic [1:0] CONT_TAG  = 2'b10;
    localparam logic [5:0] PAY_MASK  = 6'h3F;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            last;
    } result_t;

    typedef struct packed {
        logic [QCNT_W-1:0] nres;
        result_t           res0;
        result_t           res1;
        logic [CP_W-1:0]   acc_next;
        logic [REM_W-1:0]  rem_next;
    } dec_t;

    // continuation bytes that follow a lead byte in 0xC0..0xFD
    function automatic logic [REM_W-1:0] lead_count(input logic [7:0] b);
        logic [REM_W-1:0] n;
        begin
            if (b[5] == 1'b0) begin
                n = 3'd1;
            end else if (b[4] == 1'b0) begin
                n = 3'd2;
            end else if (b[3] == 1'b0) begin
                n = 3'd3;
            end else if (b[2] == 1'b0) begin
                n = 3'd4;
            end else begin
                n = 3'd5;
            end
            return n;
        end
    endfunction

endpackage

/* rtl/utf8ld_decode.sv */
// ----------------------------------------------------------------------------
// utf8ld_decode
// Per-byte decode: next accumulator state and zero, one or two results.
// ----------------------------------------------------------------------------
module utf8ld_decode (
    input  logic [7:0]                      byte_in,
    input  logic [utf8ld_pkg::CP_W-1:0]     acc,
    input  logic [utf8ld_pkg::REM_W-1:0]    rem,
    output utf8ld_pkg::dec_t                dec
);
    import utf8ld_pkg::*;

    logic                is_cont;
    logic                is_lead;
    logic                pending;
    logic [CP_W-1:0]     acc_shift;
    logic [REM_W-1:0]    rem_dec;
    logic [CP_W-1:0]     trunc;
    logic [REM_W-1:0]    cnt;
    logic [5:0]          mask;
    logic [CP_W-1:0]     byte_cp;

    assign is_cont   = (byte_in[7:6] == CONT_TAG);
    assign is_lead   = (byte_in >= LEAD_LO) && (byte_in < LEAD_HI);
    assign pending   = (rem != '0);
    assign acc_shift = {acc[CP_W-7:0], byte_in[5:0]};
    assign rem_dec   = rem - 3'd1;
    assign cnt       = lead_count(byte_in);
    assign mask      = PAY_MASK >> cnt;
    assign byte_cp   = {{(CP_W-BYTE_W){1'b0}}, byte_in};

    // missing continuations are zero-filled
    always_comb begin
        case (rem)
            3'd1:    trunc = {acc[CP_W-7:0],  6'd0};
            3'd2:    trunc = {acc[CP_W-13:0], 12'd0};
            3'd3:    trunc = {acc[CP_W-19:0], 18'd0};
            3'd4:    trunc = {acc[CP_W-25:0], 24'd0};
            3'd5:    trunc = {acc[0],         30'd0};
            3'd0:    trunc = acc;
            default: trunc = '0;
        endcase
    end

    always_comb begin
        dec = '0;
        dec.acc_next = acc;
        dec.rem_next = rem;
        if (pending && is_cont) begin
            dec.acc_next = acc_shift;
            dec.rem_next = rem_dec;
            if (rem_dec == '0) begin
                dec.nres = 2'd1;
                dec.res0 = '{code_point: acc_shift, last: 1'b1};
            end
        end else if (is_lead) begin
            dec.acc_next = {{(CP_W-6){1'b0}}, byte_in[5:0] & mask};
            dec.rem_next = cnt;
            if (pending) begin
                dec.nres = 2'd1;
                dec.res0 = '{code_point: trunc, last: 1'b1};
            end
        end else begin
            dec.acc_next = '0;
            dec.rem_next = '0;
            if (pending) begin
                dec.nres = 2'd2;
                dec.res0 = '{code_point: trunc, last: 1'b0};
                dec.res1 = '{code_point: byte_cp, last: 1'b1};
            end else begin
                dec.nres = 2'd1;
                dec.res0 = '{code_point: byte_cp, last: 1'b1};
            end
        end
    end

endmodule

/* rtl/utf8ld_outq.sv */
// ----------------------------------------------------------------------------
// utf8ld_outq
// Two-entry result queue: takes up to two results a cycle, drives m_ side.
// ----------------------------------------------------------------------------
module utf8ld_outq (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [utf8ld_pkg::QCNT_W-1:0]    push_n,
    input  utf8ld_pkg::result_t              push0,
    input  utf8ld_pkg::result_t              push1,
    output logic [utf8ld_pkg::QCNT_W-1:0]    free,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [utf8ld_pkg::TDATA_W-1:0]   m_tdata,  // [30:0] code_point, [31] zero
    output logic                             m_tlast
);
    import utf8ld_pkg::*;

    result_t             q_reg [QDEPTH];
    result_t             q_next [QDEPTH];
    logic [QCNT_W-1:0]   cnt_reg;
    logic [QCNT_W-1:0]   cnt_next;
    logic [QCNT_W-1:0]   base;
    logic                pop;
    result_t             sh0;

    assign pop      = (cnt_reg != '0) && m_tready;
    assign base     = cnt_reg - {1'b0, pop};
    assign sh0      = pop ? q_reg[1] : q_reg[0];
    // room left after this cycle's pop
    assign free     = QCNT_W'(QDEPTH) - base;
    assign cnt_next = base + push_n;

    always_comb begin
        if (base == 2'd0) begin
            q_next[0] = push0;
            q_next[1] = push1;
        end else if (base == 2'd1) begin
            q_next[0] = sh0;
            q_next[1] = push0;
        end else begin
            q_next[0] = sh0;
            q_next[1] = q_reg[1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        q_reg[0] <= q_next[0];
        q_reg[1] <= q_next[1];
    end

    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = {{(TDATA_W-CP_W){1'b0}}, q_reg[0].code_point};
    assign m_tlast  = q_reg[0].last;

endmodule

/* rtl/utf8_lenient_decoder.sv */
// ----------------------------------------------------------------------------
// utf8_lenient_decoder
// Lenient streaming decoder for legacy UTF-8 sequences of up to six bytes.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one text byte per item in s_tdata[7:0].
//   m_ channel carries decoded code points in m_tdata[30:0]; m_tlast marks
//   the final result caused by one input byte. A byte yields no result
//   (lead byte or inner continuation), one, or two (a broken sequence is
//   closed zero-filled, then the breaking byte is passed through).
// Path: an accepted byte sits in the input register, is decoded there and
//   its results are written into the output queue, whose head drives m_.
// Throughput: one byte per cycle while the receiver keeps taking results and
//   every byte gives at most one result; a byte that gives two results needs
//   both queue entries free, counting the one popped in the same cycle, so it
//   may wait in the input register. The decode itself is a single pass
//   through shift/mask logic between the input register and the queue.
// Stall: when m_tready is low the queue fills and s_tready drops once the
//   held byte no longer fits; nothing is lost or repeated.
// Reset: aresetn (sync, active low) empties both registers and clears the
//   accumulator and the pending continuation count.
// ----------------------------------------------------------------------------
module utf8_lenient_decoder (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,  // [7:0] byte_in
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [utf8ld_pkg::TDATA_W-1:0]   m_tdata,  // [30:0] code_point, [31] zero
    output logic                             m_tlast   // last
);
    import utf8ld_pkg::*;

    logic                in_valid_reg;
    logic [7:0]          in_byte_reg;
    logic [CP_W-1:0]     acc_reg;
    logic [REM_W-1:0]    rem_reg;
    dec_t                dec;
    logic [QCNT_W-1:0]   free;
    logic                fire;
    logic [QCNT_W-1:0]   push_n;

    utf8ld_decode u_decode (
        .byte_in (in_byte_reg),
        .acc     (acc_reg),
        .rem     (rem_reg),
        .dec     (dec)
    );

    assign fire     = in_valid_reg && (dec.nres <= free);
    assign s_tready = !in_valid_reg || fire;
    assign push_n   = fire ? dec.nres : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            acc_reg      <= '0;
            rem_reg      <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (fire) begin
                acc_reg <= dec.acc_next;
                rem_reg <= dec.rem_next;
            end
        end
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

    utf8ld_outq u_outq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push_n   (push_n),
        .push0    (dec.res0),
        .push1    (dec.res1),
        .free     (free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

/* rtl/utf8ld_checker.sv */
// ----------------------------------------------------------------------------
// utf8ld_checker
// Port-level checks for the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module utf8ld_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // a waiting input item holds until taken
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
        else $error("waiting input item changed");

    // out of reset: nothing to show, input side open
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("not empty after reset");

    // a closed broken sequence is always followed by the breaking byte
    a_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tlast)
        else $error("second result of a pair missing");

    // tdata padding bit stays zero
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tdata[31])
        else $error("padding bit set");

endmodule

bind utf8_lenient_decoder utf8ld_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

/* tb/utf8_lenient_decoder_chk.sv */
// ----------------------------------------------------------------------------
// utf8_lenient_decoder_chk
// Watches both streams of the decoder, predicts every code point from the
// accepted bytes and compares each result item against the oldest prediction.
// ----------------------------------------------------------------------------
module utf8_lenient_decoder_chk (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [7:0]                     s_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [utf8ld_pkg::TDATA_W-1:0] m_tdata,
    input  logic                           m_tlast,
    output int                             fail_count,
    output int                             pending_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import utf8ld_pkg::*;

    result_t          cp_expect_q[$];
    logic [CP_W-1:0]  seq_acc;
    logic [REM_W-1:0] seq_left;

    // continuations after a lead byte = number of leading ones minus one
    function automatic logic [REM_W-1:0] cont_after(input logic [7:0] b);
        int ones;
        ones = 0;
        for (int i = 7; i >= 0; i--) begin
            if (!b[i]) break;
            ones++;
        end
        return REM_W'(ones - 1);
    endfunction

    function automatic result_t mk_result(input logic [CP_W-1:0] cp, input logic lst);
        result_t r;
        r.code_point = cp;
        r.last       = lst;
        return r;
    endfunction

    task automatic decode_byte(input logic [7:0] b);
        logic [63:0]     wide;
        logic [CP_W-1:0] trunc;
        logic            closed;
        logic [REM_W-1:0] cnt;
        closed = 1'b0;
        trunc  = '0;
        if (seq_left != 0) begin
            if (b[7:6] == CONT_TAG) begin
                seq_acc  = {seq_acc[CP_W-7:0], b[5:0]};
                seq_left = seq_left - 1'b1;
                if (seq_left == 0) begin
                    cp_expect_q.push_back(mk_result(seq_acc, 1'b1));
                end
                return;
            end
            // broken sequence: missing continuations read as zero
            wide     = 64'(seq_acc) << (6 * seq_left);
            trunc    = wide[CP_W-1:0];
            closed   = 1'b1;
            seq_acc  = '0;
            seq_left = '0;
        end
        if (b >= LEAD_LO && b < LEAD_HI) begin
            cnt      = cont_after(b);
            seq_acc  = CP_W'(b & (8'(PAY_MASK) >> cnt));
            seq_left = cnt;
            if (closed) begin
                cp_expect_q.push_back(mk_result(trunc, 1'b1));
            end
        end else begin
            if (closed) begin
                cp_expect_q.push_back(mk_result(trunc, 1'b0));
            end
            cp_expect_q.push_back(mk_result(CP_W'(b), 1'b1));
        end
    endtask

    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            cp_expect_q.delete();
            seq_acc  = '0;
            seq_left = '0;
        end else begin
            // results seen at this edge come from bytes taken at earlier edges
            if (m_tvalid && m_tready) begin
                if (cp_expect_q.size() == 0) begin
                    $display("%0t: unexpected item code_point=%h last=%b", $time,
                             m_tdata[CP_W-1:0], m_tlast);
                    fail_count++;
                end else begin
                    want = cp_expect_q.pop_front();
                    if (m_tdata[CP_W-1:0] !== want.code_point) begin
                        $display("%0t: code_point expected %h actual %h", $time,
                                 want.code_point, m_tdata[CP_W-1:0]);
                        fail_count++;
                    end
                    if (m_tlast !== want.last) begin
                        $display("%0t: last expected %b actual %b", $time,
                                 want.last, m_tlast);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                decode_byte(s_tdata);
            end
        end
        pending_count = cp_expect_q.size();
    end

endmodule

/* tb/utf8_lenient_decoder_tb.sv */
// ----------------------------------------------------------------------------
// utf8_lenient_decoder_tb
// Feeds the decoder directed byte patterns and then random well-formed and
// broken UTF-8 sequences under random idling on both streams, with one long
// receiver stall; the checker predicts and compares all results.
// ----------------------------------------------------------------------------
module utf8_lenient_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import utf8ld_pkg::*;

    localparam int RANDOM_BYTES = 650;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 10;
    localparam int STALL_CYCLES = 80;

    logic               aclk;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [7:0]         s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;
    logic               m_tlast;

    int fail_count;
    int pending_count;
    int bytes_sent;
    int cycles;
    logic calm;         // no idling on either side
    logic stall_active; // receiver holding off, sender keeps pushing

    utf8_lenient_decoder uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    utf8_lenient_decoder_chk chk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = (calm || stall_active) ? 0 : idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
        @(negedge aclk);
    endtask

    function automatic logic [7:0] cont_byte();
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    // lead byte for a sequence of n bytes in total (2..6)
    function automatic logic [7:0] lead_byte(input int n);
        case (n)
            2: return 8'($urandom_range(8'hC0, 8'hDF));
            3: return 8'($urandom_range(8'hE0, 8'hEF));
            4: return 8'($urandom_range(8'hF0, 8'hF7));
            5: return 8'($urandom_range(8'hF8, 8'hFB));
            default: return 8'($urandom_range(8'hFC, 8'hFD));
        endcase
    endfunction

    task automatic send_list(input logic [7:0] seq[$]);
        foreach (seq[i]) send_byte(seq[i]);
    endtask

    // receiver: random ready, one long hold-off once traffic is flowing
    initial begin
        bit stalled_once;
        int r;
        stalled_once = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!stalled_once && bytes_sent >= 40) begin
                stalled_once = 1;
                stall_active = 1'b1;
                m_tready <= 1'b0;
                repeat (STALL_CYCLES) @(negedge aclk);
                stall_active = 1'b0;
            end else if (calm) begin
                m_tready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 65) begin
                    m_tready <= 1'b1;
                end else if (r < 97) begin
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= 1'b0;
                    repeat ($urandom_range(8, 30)) @(negedge aclk);
                end
            end
        end
    end

    initial begin
        int n;
        int r;
        int keep;
        logic [7:0] seq[$];
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        bytes_sent   = 0;
        calm         = 1'b0;
        stall_active = 1'b0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // plain bytes: zero, top ASCII, stray continuations, 0xFE, 0xFF
        send_list('{8'h00, 8'h7F, 8'h80, 8'hBF, 8'hFE, 8'hFF});
        send_list('{8'hC0, 8'h80});                             // overlong zero
        send_list('{8'hE2, 8'h82, 8'hAC});
        send_list('{8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF}); // largest value
        send_list('{8'hF8, 8'h41});                             // broken by ASCII
        send_list('{8'hFC, 8'hC3, 8'hA9});                      // broken by a lead
        send_list('{8'hF0, 8'h9F, 8'hFE});                      // broken by 0xFE

        while (bytes_sent < 25 + RANDOM_BYTES) begin
            if ($urandom_range(0, 49) == 0) calm = ~calm;
            seq.delete();
            r = $urandom_range(0, 99);
            if (r < 15) begin
                seq.push_back(8'($urandom_range(0, 127)));
            end else if (r < 80) begin
                n = $urandom_range(2, 6);
                seq.push_back(lead_byte(n));
                repeat (n - 1) seq.push_back(cont_byte());
            end else if (r < 90) begin
                // truncated sequence, the next byte that is not a continuation breaks into it
                n = $urandom_range(2, 6);
                keep = $urandom_range(0, n - 2);
                seq.push_back(lead_byte(n));
                repeat (keep) seq.push_back(cont_byte());
            end else begin
                seq.push_back(8'($urandom_range(0, 255)));
            end
            send_list(seq);
        end
        s_tvalid <= 1'b0;
        calm = 1'b0;

        @(negedge aclk);
        while (pending_count != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/utf8ld_pkg.sv
rtl/utf8ld_decode.sv
rtl/utf8ld_outq.sv
rtl/utf8_lenient_decoder.sv
rtl/utf8ld_checker.sv
tb/utf8_lenient_decoder_chk.sv
tb/utf8_lenient_decoder_tb.sv
